>>> hw/rtl/mafd_pkg.sv
package mafd_pkg;

  // default sizes
  localparam int RING_DEPTH_DEFAULT  = 2048;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  // fixed field widths
  localparam int GAIN_BITS      = 16;
  localparam int LENGTH_BITS    = 12;
  localparam int WHOLE_BITS     = 11;
  localparam int FRAC_BITS      = 8;
  localparam int COEF_BITS      = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [LENGTH_BITS-1:0] RING_LENGTH_RESET = 12'd2048;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FEEDBACK_GAIN = 1'b0,
    REG_RING_LENGTH   = 1'b1
  } cfg_reg_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RD1,
    S_RD2,
    S_RD3,
    S_DIV,
    S_MUL_V,
    S_UPD_V,
    S_MUL_G1,
    S_UPD_XH,
    S_MUL_G2,
    S_OUT
  } state_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_COEF,
    MUL_GAIN_V,
    MUL_GAIN_XH
  } mul_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic     clr_we;
    logic     load;
    logic     addr;
    logic     rd_r2;
    logic     cap_f1;
    logic     cap_f2;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_v;
    logic     upd_xh;
    logic     out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/mafd_ram.sv
module mafd_ram #(
  parameter int WIDTH = mafd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int DEPTH = mafd_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mafd_div.sv
module mafd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mafd_pkg::FRAC_BITS-1:0] frac,
  output logic                           busy,
  output logic [mafd_pkg::COEF_BITS-1:0] quot
);

  // (256 - f) * 2^15 / (256 + f), restoring, two quotient bits per cycle
  localparam int DEN_BITS = mafd_pkg::FRAC_BITS + 1;
  localparam int QB       = mafd_pkg::COEF_BITS;
  localparam int CYCLES   = QB / 2;
  localparam int CNT_BITS = $clog2(CYCLES);
  localparam logic [DEN_BITS-1:0] FULL = DEN_BITS'(1 << mafd_pkg::FRAC_BITS);

  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [QB-1:0]       num;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS-1:0] rem_next;
  logic [QB-1:0]       quot_next;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS-1:0] num_hi;
  logic [DEN_BITS-1:0] den_start;

  assign num_hi    = FULL - {1'b0, frac};
  assign den_start = FULL + {1'b0, frac};

  // two dependent compare/subtract steps
  always_comb begin
    rem_next  = rem;
    quot_next = quot;
    trial     = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_next, num[QB-1-i]};
      if (trial >= {1'b0, den}) begin
        rem_next  = DEN_BITS'(trial - {1'b0, den});
        quot_next = {quot_next[QB-2:0], 1'b1};
      end else begin
        rem_next  = trial[DEN_BITS-1:0];
        quot_next = {quot_next[QB-2:0], 1'b0};
      end
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= CNT_BITS'(cnt + 1'b1);
      if (cnt == CNT_BITS'(CYCLES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // operands and partial quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num_hi[DEN_BITS-1:1]};
      num  <= {num_hi[0], {(QB-1){1'b0}}};
      den  <= den_start;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      num  <= {num[QB-3:0], 2'b00};
      quot <= quot_next;
    end
  end

endmodule

>>> hw/rtl/mafd_datapath.sv
module mafd_datapath #(
  parameter int RING_DEPTH  = mafd_pkg::RING_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = mafd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mafd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mafd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic [mafd_pkg::WHOLE_BITS-1:0]     delay_whole,
  input  logic [mafd_pkg::FRAC_BITS-1:0]      delay_frac,
  input  mafd_pkg::cmd_t                      cmd,
  output mafd_pkg::status_t                   status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [SAMPLE_BITS-1:0]       sample_out
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LW = (AW + 1 > mafd_pkg::LENGTH_BITS) ? AW + 1 : mafd_pkg::LENGTH_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int GB = mafd_pkg::GAIN_BITS;
  localparam int AB = mafd_pkg::COEF_BITS + 1;
  localparam int PW = SB + 18;
  localparam int RW = PW - 15;
  localparam int SW = SB + 4;
  localparam logic [LW-1:0] LEN_MIN = LW'(4);
  localparam logic [LW-1:0] LEN_MAX = LW'(RING_DEPTH);
  localparam logic signed [PW-1:0] RND_HALF = PW'(16384);

  function automatic logic signed [SB-1:0] sat(input logic signed [SW-1:0] a);
    logic signed [SB-1:0] r;
    if (a[SW-1:SB-1] == {(SW-SB+1){a[SW-1]}}) begin
      r = a[SB-1:0];
    end else if (a[SW-1]) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration and state
  logic signed [GB-1:0]              gain;
  logic [mafd_pkg::LENGTH_BITS-1:0]  ring_length;
  logic [AW-1:0]                     wp;
  logic [AW-1:0]                     clr_cnt;
  logic signed [SB-1:0]              ip;

  // per-transaction working registers
  logic [LW-1:0]          len;
  logic [LW-1:0]          wp_e;
  logic [LW-1:0]          d_raw;
  logic [LW-1:0]          r1;
  logic signed [SB-1:0]   x;
  logic signed [SB-1:0]   f1;
  logic signed [SB-1:0]   f2;
  logic signed [SB-1:0]   xh;
  logic signed [PW-1:0]   prod;

  // combinational values
  logic [LW-1:0]          rl;
  logic [LW-1:0]          len_next;
  logic [LW-1:0]          wp_ext;
  logic [LW-1:0]          wp_e_next;
  logic [LW-1:0]          d_lim;
  logic [LW-1:0]          d_cl;
  logic [LW-1:0]          r1_next;
  logic [LW-1:0]          r2;
  logic [LW-1:0]          wp_inc;
  logic [LW-1:0]          wp_adv;
  logic [mafd_pkg::COEF_BITS-1:0] coef;
  logic                   div_busy;
  logic signed [AB-1:0]   mul_a;
  logic signed [SB:0]     mul_b;
  logic signed [PW-1:0]   prod_r;
  logic signed [RW-1:0]   rnd;
  logic signed [SB-1:0]   v_next;
  logic signed [SB-1:0]   xh_next;
  logic signed [SB-1:0]   y_next;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SB-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [SB-1:0]          ram_rdata;

  // effective length and write position
  always_comb begin
    rl = LW'(ring_length);
    if (rl < LEN_MIN) begin
      len_next = LEN_MIN;
    end else if (rl > LEN_MAX) begin
      len_next = LEN_MAX;
    end else begin
      len_next = rl;
    end
    wp_ext    = LW'(wp);
    wp_e_next = (wp_ext >= len_next) ? '0 : wp_ext;
  end

  // read addresses: newer tap r1, older tap r2
  always_comb begin
    d_lim   = LW'(len - LW'(2));
    d_cl    = (d_raw > d_lim) ? d_lim : d_raw;
    r1_next = (wp_e >= d_cl) ? LW'(wp_e - d_cl) : LW'(wp_e + len - d_cl);
    r2      = (r1 == '0) ? LW'(len - LW'(1)) : LW'(r1 - LW'(1));
    wp_inc  = LW'(wp_e + LW'(1));
    wp_adv  = (wp_inc >= len) ? '0 : wp_inc;
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      mafd_pkg::MUL_COEF: begin
        mul_a = {1'b0, coef};
        mul_b = (SB+1)'(f1) - (SB+1)'(ip);
      end
      mafd_pkg::MUL_GAIN_V: begin
        mul_a = AB'(gain);
        mul_b = (SB+1)'(ip);
      end
      mafd_pkg::MUL_GAIN_XH: begin
        mul_a = AB'(gain);
        mul_b = (SB+1)'(xh);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up, add, saturate
  assign prod_r  = prod + RND_HALF;
  assign rnd     = prod_r[PW-1:15];
  assign v_next  = sat(SW'(f2) + SW'(rnd));
  assign xh_next = sat(SW'(x) - SW'(rnd));
  assign y_next  = sat(SW'(rnd) + SW'(ip));

  // ring port muxing
  assign ram_we    = cmd.clr_we | cmd.upd_xh;
  assign ram_waddr = cmd.clr_we ? clr_cnt : wp_e[AW-1:0];
  assign ram_wdata = cmd.clr_we ? '0 : xh_next;
  assign ram_raddr = cmd.rd_r2 ? r2[AW-1:0] : r1[AW-1:0];

  mafd_ram #(
    .WIDTH(SB),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mafd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.load),
    .frac (delay_frac),
    .busy (div_busy),
    .quot (coef)
  );

  // status to controller
  assign status.clr_last = (clr_cnt == AW'(RING_DEPTH - 1));
  assign status.div_busy = div_busy;
  assign status.out_free = ~out_valid | out_ready;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gain        <= '0;
      ring_length <= mafd_pkg::RING_LENGTH_RESET;
      wp          <= '0;
      clr_cnt     <= '0;
      ip          <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (mafd_pkg::cfg_reg_t'(cfg_index))
          mafd_pkg::REG_FEEDBACK_GAIN: gain <= cfg_data[GB-1:0];
          mafd_pkg::REG_RING_LENGTH:   ring_length <= cfg_data[mafd_pkg::LENGTH_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_we) begin
        clr_cnt <= AW'(clr_cnt + 1'b1);
      end
      if (cmd.upd_v) begin
        ip <= v_next;
      end
      if (cmd.upd_xh) begin
        wp <= wp_adv[AW-1:0];
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len   <= len_next;
      wp_e  <= wp_e_next;
      d_raw <= LW'(delay_whole);
      x     <= sample_in;
    end
    if (cmd.addr) begin
      r1 <= r1_next;
    end
    if (cmd.cap_f1) begin
      f1 <= ram_rdata;
    end
    if (cmd.cap_f2) begin
      f2 <= ram_rdata;
    end
    if (cmd.mul_en) begin
      prod <= PW'(mul_a) * PW'(mul_b);
    end
    if (cmd.upd_xh) begin
      xh <= xh_next;
    end
    if (cmd.out_load) begin
      sample_out <= y_next;
    end
  end

endmodule

>>> hw/rtl/mafd_ctrl.sv
module mafd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mafd_pkg::status_t status,
  output mafd_pkg::cmd_t    cmd
);

  mafd_pkg::state_t state;
  mafd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mafd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mafd_pkg::S_CLEAR:  if (status.clr_last) state_next = mafd_pkg::S_IDLE;
      mafd_pkg::S_IDLE:   if (in_valid) state_next = mafd_pkg::S_ADDR;
      mafd_pkg::S_ADDR:   state_next = mafd_pkg::S_RD1;
      mafd_pkg::S_RD1:    state_next = mafd_pkg::S_RD2;
      mafd_pkg::S_RD2:    state_next = mafd_pkg::S_RD3;
      mafd_pkg::S_RD3:    state_next = mafd_pkg::S_DIV;
      mafd_pkg::S_DIV:    if (!status.div_busy) state_next = mafd_pkg::S_MUL_V;
      mafd_pkg::S_MUL_V:  state_next = mafd_pkg::S_UPD_V;
      mafd_pkg::S_UPD_V:  state_next = mafd_pkg::S_MUL_G1;
      mafd_pkg::S_MUL_G1: state_next = mafd_pkg::S_UPD_XH;
      mafd_pkg::S_UPD_XH: state_next = mafd_pkg::S_MUL_G2;
      mafd_pkg::S_MUL_G2: state_next = mafd_pkg::S_OUT;
      mafd_pkg::S_OUT:    if (status.out_free) state_next = mafd_pkg::S_IDLE;
      default:            state_next = mafd_pkg::S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = mafd_pkg::MUL_COEF;
    in_ready    = 1'b0;
    case (state)
      mafd_pkg::S_CLEAR: cmd.clr_we = 1'b1;
      mafd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mafd_pkg::S_ADDR:  cmd.addr = 1'b1;
      mafd_pkg::S_RD1:   cmd.rd_r2 = 1'b0;
      mafd_pkg::S_RD2: begin
        cmd.rd_r2  = 1'b1;
        cmd.cap_f1 = 1'b1;
      end
      mafd_pkg::S_RD3:   cmd.cap_f2 = 1'b1;
      mafd_pkg::S_DIV:   cmd.mul_en = 1'b0;
      mafd_pkg::S_MUL_V: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mafd_pkg::MUL_COEF;
      end
      mafd_pkg::S_UPD_V: cmd.upd_v = 1'b1;
      mafd_pkg::S_MUL_G1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mafd_pkg::MUL_GAIN_V;
      end
      mafd_pkg::S_UPD_XH: cmd.upd_xh = 1'b1;
      mafd_pkg::S_MUL_G2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mafd_pkg::MUL_GAIN_XH;
      end
      mafd_pkg::S_OUT:   cmd.out_load = status.out_free;
      default:           cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/modulated_allpass_fractional_delay_unit.sv
// Each sample, taken in S_IDLE, runs through S_ADDR, S_RD1 to S_RD3, S_DIV
// (waiting on the coefficient divider, two quotient bits a cycle), the
// three dependent multiply-and-round steps on the one shared multiplier
// and S_OUT, which registers the result once the output is free; only then
// is a new sample accepted, and it may enter while the last result waits.
// Reset: synchronous; the RING_DEPTH ring entries (2048 by default) are
// then zeroed with input ready low, while configuration writes are taken.
module modulated_allpass_fractional_delay_unit #(
  parameter int RING_DEPTH  = mafd_pkg::RING_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = mafd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mafd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mafd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic [mafd_pkg::WHOLE_BITS-1:0]     delay_whole,
  input  logic [mafd_pkg::FRAC_BITS-1:0]      delay_frac,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       sample_out
);

  mafd_pkg::cmd_t    cmd;
  mafd_pkg::status_t status;

  mafd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  mafd_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .delay_whole(delay_whole),
    .delay_frac (delay_frac),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .sample_out (sample_out)
  );

endmodule

>>> tb/sv/tb_modulated_allpass_fractional_delay_unit.sv
`timescale 1ns / 100ps

module tb_modulated_allpass_fractional_delay_unit;

  localparam int     RING_DEPTH     = mafd_pkg::RING_DEPTH_DEFAULT;
  localparam int     SAMPLE_BITS    = mafd_pkg::SAMPLE_BITS_DEFAULT;
  localparam int     WHOLE_BITS     = mafd_pkg::WHOLE_BITS;
  localparam int     FRAC_BITS      = mafd_pkg::FRAC_BITS;
  localparam int     CFG_DATA_BITS  = mafd_pkg::CFG_DATA_BITS;
  localparam int     LENGTH_BITS    = mafd_pkg::LENGTH_BITS;
  localparam longint SAT_HI         = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO         = -SAT_HI - 1;
  localparam int     WATCHDOG_LIMIT = 10000;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     PHASES         = 10;
  localparam int     PHASE_ITEMS    = 185;
  localparam int     NPLAN          = 30;
  localparam int     MAX_REPORTS    = 10;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WHOLE_BITS-1:0]         whole_t;
  typedef logic [FRAC_BITS-1:0]          frac_t;

  // one row of the directed table: a register write or a sample
  typedef struct packed {
    logic                     is_write;
    mafd_pkg::cfg_reg_t       reg_sel;
    logic [CFG_DATA_BITS-1:0] value;
    logic [SAMPLE_BITS-1:0]   smp;
    whole_t                   whole;
    frac_t                    frac;
    logic                     known;
    logic [SAMPLE_BITS-1:0]   want;
  } step_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  mafd_pkg::cfg_reg_t       cfg_index = mafd_pkg::REG_FEEDBACK_GAIN;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  sample_t                  sample_in = '0;
  whole_t                   delay_whole = '0;
  frac_t                    delay_frac = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  sample_t                  sample_out;

  // mirror of the block state and registers
  sample_t     ring_mirror [RING_DEPTH];
  int unsigned wpos_mirror = 0;
  longint      interp_mirror = 0;
  longint      gain_mirror = 0;
  int unsigned length_mirror = RING_DEPTH;

  sample_t pending_out [$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      hold_asked = 0;
  int      hold_served = 0;
  bit      last_stretch = 1'b0;
  bit      row_known = 1'b0;
  sample_t row_want = '0;
  step_t   plan [NPLAN];

  int gain_set [PHASES] = '{32767, -32768, 0, 23170, -20000, 0, 12000, -9000, 30000, -32768};
  int len_set  [PHASES] = '{4, 2048, 3, 37, 4095, 0, 300, 9, 64, 2048};

  modulated_allpass_fractional_delay_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .delay_whole (delay_whole),
    .delay_frac  (delay_frac),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // clamp to the signed sample range
  function automatic longint clip(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Q15 product back to integer, round half up
  function automatic longint round_q15(input longint p);
    return (p + 64'sd16384) >>> 15;
  endfunction

  // one allpass step: updates the mirror, returns the output sample
  function automatic sample_t allpass_predict(input sample_t x, input whole_t whole,
                                              input frac_t frac);
    int unsigned len, wp, d, r1, r2, fv, coef;
    longint      f1, f2, v, xh, y;
    len = length_mirror;
    if (len < 4) len = 4;
    if (len > RING_DEPTH) len = RING_DEPTH;
    wp = wpos_mirror;
    if (wp >= len) wp = 0;
    d = whole;
    if (d > len - 2) d = len - 2;
    r1 = (wp >= d) ? (wp - d) : (wp + len - d);
    r2 = (r1 == 0) ? (len - 1) : (r1 - 1);
    f1 = ring_mirror[r1];
    f2 = ring_mirror[r2];
    // Thiran coefficient (1-f)/(1+f) in Q1.15
    fv = frac;
    coef = ((256 - fv) << 15) / (256 + fv);
    v = clip(f2 + round_q15(longint'(coef) * (f1 - interp_mirror)));
    interp_mirror = v;
    xh = clip(longint'(x) - round_q15(gain_mirror * v));
    y = clip(round_q15(gain_mirror * xh) + v);
    ring_mirror[wp] = sample_t'(xh);
    wp++;
    if (wp >= len) wp = 0;
    wpos_mirror = wp;
    return sample_t'(y);
  endfunction

  function automatic step_t reg_step(input mafd_pkg::cfg_reg_t r,
                                     input logic [CFG_DATA_BITS-1:0] v);
    step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.reg_sel = r;
    s.value = v;
    return s;
  endfunction

  function automatic step_t sample_step(input int smp, input int whole, input int frac);
    step_t s;
    s = '0;
    s.smp = SAMPLE_BITS'(smp);
    s.whole = whole_t'(whole);
    s.frac = frac_t'(frac);
    return s;
  endfunction

  // sample whose reads all land on still-cleared entries with zero gain
  function automatic step_t silent_step(input int smp, input int whole, input int frac);
    step_t s;
    s = sample_step(smp, whole, frac);
    s.known = 1'b1;
    s.want = '0;
    return s;
  endfunction

  // present one sample, with an occasional gap first, and wait for its transaction
  task automatic push_sample(input sample_t s, input whole_t w, input frac_t f,
                             input bit known, input sample_t want);
    @(negedge clk);
    if (!last_stretch && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= s;
    delay_whole <= w;
    delay_frac  <= f;
    row_known = known;
    row_want = want;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every expected result is in
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input mafd_pkg::cfg_reg_t r,
                           input logic [CFG_DATA_BITS-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stimulus
  initial begin
    int                       pick, ring_len, leff;
    logic [CFG_DATA_BITS-1:0] gain_word;
    sample_t                  smp;
    whole_t                   whole;
    frac_t                    frac;

    foreach (ring_mirror[i]) ring_mirror[i] = '0;

    plan = '{
      reg_step(mafd_pkg::REG_FEEDBACK_GAIN, 16'h0000),
      reg_step(mafd_pkg::REG_RING_LENGTH, 16'd2048),
      silent_step(8388607, 2046, 0),
      silent_step(-8388608, 2047, 255),
      silent_step(5592405, 1000, 128),
      sample_step(-5592406, 0, 0),
      sample_step(1, 1, 255),
      sample_step(-1, 2, 1),
      reg_step(mafd_pkg::REG_FEEDBACK_GAIN, 16'h7FFF),
      sample_step(8388607, 1, 0),
      sample_step(8388607, 1, 255),
      sample_step(-8388608, 3, 64),
      sample_step(-8388608, 0, 200),
      reg_step(mafd_pkg::REG_FEEDBACK_GAIN, 16'h8000),
      sample_step(8388607, 1, 0),
      sample_step(-8388608, 2, 255),
      sample_step(8388607, 5, 17),
      // shrink: write position falls beyond the length and restarts at zero
      reg_step(mafd_pkg::REG_RING_LENGTH, 16'd4),
      sample_step(1193046, 0, 0),
      sample_step(-8388608, 2, 255),
      sample_step(8388607, 2046, 100),
      sample_step(-1193046, 1, 0),
      // lengths outside the legal range get clamped
      reg_step(mafd_pkg::REG_RING_LENGTH, 16'd0),
      sample_step(8388607, 2, 128),
      sample_step(-8388608, 7, 3),
      reg_step(mafd_pkg::REG_RING_LENGTH, 16'd4095),
      reg_step(mafd_pkg::REG_FEEDBACK_GAIN, 16'h4000),
      sample_step(8388607, 2046, 255),
      sample_step(4194304, 2047, 0),
      sample_step(-8388608, 0, 128)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NPLAN; i++) begin
      if (plan[i].is_write) begin
        wait_quiet();
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        push_sample(sample_t'(plan[i].smp), plan[i].whole, plan[i].frac,
                    plan[i].known, sample_t'(plan[i].want));
      end
    end

    // random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      gain_word = (ph == 2 || ph == 5) ? CFG_DATA_BITS'($urandom_range(0, 65535))
                                       : CFG_DATA_BITS'(gain_set[ph]);
      ring_len = (ph == 6) ? int'($urandom_range(4, RING_DEPTH)) : len_set[ph];
      leff = (ring_len < 4) ? 4 : ((ring_len > RING_DEPTH) ? RING_DEPTH : ring_len);
      if (ph == PHASES - 1) last_stretch = 1'b1;
      wait_quiet();
      write_reg(mafd_pkg::REG_FEEDBACK_GAIN, gain_word);
      write_reg(mafd_pkg::REG_RING_LENGTH, CFG_DATA_BITS'(ring_len));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) hold_asked++;
        if (ph == 3 && n == 90) wait_quiet();
        pick = $urandom_range(0, 19);
        if (pick < 12) smp = sample_t'($urandom);
        else if (pick < 14) smp = sample_t'(SAT_HI);
        else if (pick < 16) smp = sample_t'(SAT_LO);
        else smp = sample_t'(int'($urandom_range(0, 131071)) - 65536);
        // delays mostly inside the ring, some past it, some at the edges
        pick = $urandom_range(0, 9);
        if (pick < 8) whole = whole_t'($urandom_range(0, leff - 2));
        else if (pick == 8) whole = whole_t'($urandom);
        else whole = ($urandom_range(0, 1) != 0) ? whole_t'(1) : whole_t'(leff - 2);
        pick = $urandom_range(0, 9);
        if (pick == 0) frac = '0;
        else if (pick == 1) frac = '1;
        else frac = frac_t'($urandom);
        push_sample(smp, whole, frac, 1'b0, '0);
      end
    end

    wait_quiet();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && pending_out.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!last_stretch && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // register mirror, expected samples and result check
  always @(posedge clk) begin
    sample_t predicted;
    sample_t expected;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == mafd_pkg::REG_FEEDBACK_GAIN)
          gain_mirror = longint'($signed(cfg_data));
        else length_mirror = cfg_data[LENGTH_BITS-1:0];
      end
      if (in_valid && in_ready) begin
        predicted = allpass_predict(sample_in, delay_whole, delay_frac);
        pending_out.push_back(row_known ? row_want : predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_out.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected output transaction: sample_out %0d", sample_out);
        end else begin
          expected = pending_out.pop_front();
          if (sample_out !== expected) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("sample_out mismatch: expected %0d, got %0d", expected, sample_out);
          end
        end
      end
    end
  end

  // watchdog: too long without any transaction
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
